// ----- rtl/core/http_byte_range_parser_macros.svh -----
// Assertion macros for the byte range parser.
`ifndef HTTP_BYTE_RANGE_PARSER_MACROS_SVH
`define HTTP_BYTE_RANGE_PARSER_MACROS_SVH
`ifndef ASSERT_OFF
// Checks that a condition implies a consequence in the same cycle.
`define HRP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrp: same-cycle implication failed");
// Checks that a condition implies a consequence in the next cycle.
`define HRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrp: next-cycle implication failed");
`else
`define HRP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define HRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/hrp_pkg.sv -----
// Package with the types and constants shared by the byte range parser.
package hrp_pkg;

    localparam int OUT_W = 63;

    localparam logic [1:0] OUTCOME_PARTIAL = 2'd0;
    localparam logic [1:0] OUTCOME_FULL    = 2'd1;
    localparam logic [1:0] OUTCOME_BAD     = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0] PREFIX_LEN = 4'd6;
    localparam logic [3:0] MIN_LEN    = 4'd8;

    typedef enum logic [6:0] {
        PH_PREFIX  = 7'b0000001,
        PH_LEAD    = 7'b0000010,
        PH_START   = 7'b0000100,
        PH_GAP     = 7'b0001000,
        PH_ENDLEAD = 7'b0010000,
        PH_ENDNUM  = 7'b0100000,
        PH_TAIL    = 7'b1000000
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_FULL = 2'd1,
        EV_BAD  = 2'd2
    } t_early;

    // What the final stage still has to decide for a finished value.
    typedef enum logic [1:0] {
        K_FULL  = 2'd0,
        K_BAD   = 2'd1,
        K_RANGE = 2'd2
    } t_kind;

    typedef struct packed {
        logic  short_value;
        t_kind kind;
        logic  end_given;
    } t_fin;

    // The expected "bytes=" prefix, one character per position.
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h62;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h73;
            3'd5:    c = 8'h3D;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/hrp_parse.sv -----
// Per-byte parse state machine and decimal accumulators of the range parser.
module hrp_parse
    import hrp_pkg::*;
#(
    parameter int OFFSET_BITS = 63
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [7:0]             i_value_byte,
    input  logic                   i_last_byte,
    output t_fin                   o_fin,
    output logic [OFFSET_BITS-1:0] o_start,
    output logic [OFFSET_BITS-1:0] o_end
);

    localparam logic [OFFSET_BITS-1:0] DEC_LIMIT =
        OFFSET_BITS'(((64'd1 << OFFSET_BITS) - 64'd1) / 64'd10);

    t_phase                 r_phase, n_phase;
    t_early                 r_ev, n_ev;
    logic [3:0]             r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [OFFSET_BITS-1:0] r_end, n_end;
    logic                   r_eg, n_eg;

    logic                   is_digit;
    logic [OFFSET_BITS-1:0] digit_val;
    logic [OFFSET_BITS-1:0] start_acc, end_acc;

    assign is_digit  = (i_value_byte >= CH_ZERO) && (i_value_byte <= CH_NINE);
    assign digit_val = OFFSET_BITS'(i_value_byte[3:0]);
    assign start_acc = (r_start << 3) + (r_start << 1) + digit_val;
    assign end_acc   = (r_end << 3) + (r_end << 1) + digit_val;

    always_comb begin
        n_phase = r_phase;
        n_ev    = r_ev;
        n_start = r_start;
        n_end   = r_end;
        n_eg    = r_eg;
        n_pos   = (r_pos < MIN_LEN) ? r_pos + 4'd1 : r_pos;
        if (r_ev == EV_NONE) begin
            unique case (r_phase)
                PH_PREFIX: begin
                    if (r_pos >= PREFIX_LEN || i_value_byte != prefix_char(r_pos[2:0])) begin
                        n_ev = EV_FULL;
                    end else if (r_pos == PREFIX_LEN - 4'd1) begin
                        n_phase = PH_LEAD;
                    end
                end
                PH_LEAD: begin
                    if (i_value_byte == CH_SPACE) begin
                        n_phase = PH_LEAD;
                    end else if (is_digit) begin
                        n_start = digit_val;
                        n_phase = PH_START;
                    end else begin
                        n_ev = EV_BAD;
                    end
                end
                PH_START: begin
                    if (is_digit) begin
                        if (r_start >= DEC_LIMIT) begin
                            n_ev = EV_BAD;
                        end else begin
                            n_start = start_acc;
                        end
                    end else if (i_value_byte == CH_SPACE) begin
                        n_phase = PH_GAP;
                    end else if (i_value_byte == CH_DASH) begin
                        n_phase = PH_ENDLEAD;
                    end else begin
                        n_ev = EV_BAD;
                    end
                end
                PH_GAP: begin
                    if (i_value_byte == CH_DASH) begin
                        n_phase = PH_ENDLEAD;
                    end else if (i_value_byte != CH_SPACE) begin
                        n_ev = EV_BAD;
                    end
                end
                PH_ENDLEAD: begin
                    if (is_digit) begin
                        n_end   = digit_val;
                        n_eg    = 1'b1;
                        n_phase = PH_ENDNUM;
                    end else if (i_value_byte != CH_SPACE &&
                                 !(i_value_byte == CH_NUL && i_last_byte)) begin
                        // A NUL as the very last byte stands for an open end.
                        n_ev = EV_FULL;
                    end
                end
                PH_ENDNUM: begin
                    if (is_digit) begin
                        if (r_end >= DEC_LIMIT) begin
                            n_ev = EV_BAD;
                        end else begin
                            n_end = end_acc;
                        end
                    end else if (i_value_byte == CH_SPACE || i_value_byte == CH_NUL) begin
                        n_phase = PH_TAIL;
                    end else begin
                        n_ev = EV_FULL;
                    end
                end
                PH_TAIL: begin
                    if (i_value_byte != CH_SPACE && i_value_byte != CH_NUL) begin
                        n_ev = EV_FULL;
                    end
                end
                default: begin
                    n_ev = EV_FULL;
                end
            endcase
        end
    end

    // Classify the value as it stands after this byte.
    always_comb begin
        o_fin.short_value = (n_pos < MIN_LEN);
        o_fin.end_given   = n_eg;
        unique case (n_ev)
            EV_FULL: o_fin.kind = K_FULL;
            EV_BAD:  o_fin.kind = K_BAD;
            default: begin
                if (n_phase == PH_START || n_phase == PH_GAP) begin
                    o_fin.kind = K_BAD;
                end else if (n_phase == PH_ENDLEAD || n_phase == PH_ENDNUM ||
                             n_phase == PH_TAIL) begin
                    o_fin.kind = K_RANGE;
                end else begin
                    o_fin.kind = K_FULL;
                end
            end
        endcase
    end

    assign o_start = n_start;
    assign o_end   = n_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PREFIX;
            r_ev    <= EV_NONE;
            r_pos   <= 4'd0;
            r_start <= '0;
            r_end   <= '0;
            r_eg    <= 1'b0;
        end else if (i_step) begin
            if (i_last_byte) begin
                r_phase <= PH_PREFIX;
                r_ev    <= EV_NONE;
                r_pos   <= 4'd0;
                r_start <= '0;
                r_end   <= '0;
                r_eg    <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_ev    <= n_ev;
                r_pos   <= n_pos;
                r_start <= n_start;
                r_end   <= n_end;
                r_eg    <= n_eg;
            end
        end
    end

endmodule

// ----- rtl/core/http_byte_range_parser.sv -----
// Top level of the HTTP Range header parser for one byte range.
// Throughput: one header byte per cycle; input ready drops only while a verdict is stuck.
// A verdict is registered first in the snapshot register and then in the output register.
// Stage one is the parse state machine, stage two the end clamp and start/end compare.
// Reset is synchronous and active low: parse state clears, the file size becomes zero,
// and both verdict stages empty.
`include "http_byte_range_parser_macros.svh"
module http_byte_range_parser
    import hrp_pkg::*;
#(
    parameter int OFFSET_BITS = 63
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Configuration: file size in bytes.
    input  logic             i_cfg_we,
    input  logic [OUT_W-1:0] i_cfg_wdata,
    // Header value bytes.
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_value_byte,
    input  logic             i_last_byte,
    // Verdicts.
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_outcome,
    output logic [OUT_W-1:0] o_first_offset,
    output logic [OUT_W-1:0] o_final_offset
);

    // File size and its value minus one, both kept so the clamp needs no subtractor.
    logic [OFFSET_BITS-1:0] r_fs;
    logic [OFFSET_BITS-1:0] r_fs_m1;

    // Snapshot of a finished value, waiting for the clamp stage.
    logic                   r_fin_valid;
    t_fin                   r_fin;
    logic [OFFSET_BITS-1:0] r_fin_start;
    logic [OFFSET_BITS-1:0] r_fin_end;

    // Output register.
    logic                   r_out_valid;
    logic [1:0]             r_outcome;
    logic [OUT_W-1:0]       r_first;
    logic [OUT_W-1:0]       r_final;

    logic                   step;
    logic                   fin_move;
    t_fin                   parse_fin;
    logic [OFFSET_BITS-1:0] parse_start;
    logic [OFFSET_BITS-1:0] parse_end;

    logic [1:0]             n_outcome;
    logic [OUT_W-1:0]       n_first;
    logic [OUT_W-1:0]       n_final;
    logic                   end_past_file;
    logic [OFFSET_BITS-1:0] clamped_end;

    // The snapshot stage moves on whenever the output register is empty or being drained.
    // The input stalls only while the snapshot holds a verdict and the output register
    // holds another one that is not being taken.
    assign fin_move   = r_fin_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_fin_valid || fin_move;
    assign step       = i_in_valid && o_in_ready;

    hrp_parse #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_value_byte(i_value_byte),
        .i_last_byte (i_last_byte),
        .o_fin       (parse_fin),
        .o_start     (parse_start),
        .o_end       (parse_end)
    );

    // End clamp: an open end, or an end at or past the file size, becomes size minus one.
    assign end_past_file = (r_fin_end >= r_fs);
    assign clamped_end   = (r_fin.end_given && !end_past_file) ? r_fin_end : r_fs_m1;

    always_comb begin
        n_outcome = OUTCOME_FULL;
        n_first   = '0;
        n_final   = '0;
        // An empty file or a value shorter than eight bytes always sends the whole file.
        if (r_fs != '0 && !r_fin.short_value) begin
            case (r_fin.kind)
                K_BAD: begin
                    n_outcome = OUTCOME_BAD;
                end
                K_RANGE: begin
                    if (r_fin_start > clamped_end) begin
                        n_outcome = OUTCOME_BAD;
                    end else begin
                        n_outcome = OUTCOME_PARTIAL;
                        n_first   = OUT_W'(r_fin_start);
                        n_final   = OUT_W'(clamped_end);
                    end
                end
                default: begin
                    n_outcome = OUTCOME_FULL;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs        <= '0;
            r_fs_m1     <= '1;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fs    <= OFFSET_BITS'(i_cfg_wdata);
                r_fs_m1 <= OFFSET_BITS'(i_cfg_wdata) - OFFSET_BITS'(1);
            end
            if (step && i_last_byte) begin
                r_fin_valid <= 1'b1;
            end else if (fin_move) begin
                r_fin_valid <= 1'b0;
            end
            if (fin_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (step && i_last_byte) begin
            r_fin       <= parse_fin;
            r_fin_start <= parse_start;
            r_fin_end   <= parse_end;
        end
        if (fin_move) begin
            r_outcome <= n_outcome;
            r_first   <= n_first;
            r_final   <= n_final;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_outcome      = r_outcome;
    assign o_first_offset = r_first;
    assign o_final_offset = r_final;

    // A partial range never starts after its end.
    `HRP_ASSERT_IMPLY(a_partial_ordered, i_clk, i_rst_n, o_out_valid && o_outcome == OUTCOME_PARTIAL, o_first_offset <= o_final_offset)
    // A partial range always ends inside the file.
    `HRP_ASSERT_IMPLY(a_partial_in_file, i_clk, i_rst_n, o_out_valid && o_outcome == OUTCOME_PARTIAL, o_final_offset < OUT_W'(r_fs))
    // Any verdict other than partial carries zero offsets.
    `HRP_ASSERT_IMPLY(a_other_zero, i_clk, i_rst_n, o_out_valid && o_outcome != OUTCOME_PARTIAL, o_first_offset == '0 && o_final_offset == '0)
    // A snapshot that does not move on to the output register stays held.
    `HRP_ASSERT_NEXT(a_fin_held, i_clk, i_rst_n, r_fin_valid && !fin_move, r_fin_valid)

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the HTTP single byte range parser.
`timescale 1ns / 1ps

module testbench
    import hrp_pkg::*;
();

    // The decimal accumulators refuse a further digit once they reach this value.
    localparam logic [63:0] DEC_LIMIT = ((64'd1 << OUT_W) - 64'd1) / 64'd10;
    localparam logic [63:0] SIZE_MAX  = (64'd1 << OUT_W) - 64'd1;
    // The range unit that must open every header value, first character in the top byte.
    localparam logic [47:0] UNIT_TEXT = "bytes=";
    localparam int IDLE_PCT = 21;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_hdr_byte;

    typedef struct packed {
        logic [1:0]       outcome;
        logic [OUT_W-1:0] first_offset;
        logic [OUT_W-1:0] final_offset;
    } t_range_verdict;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [OUT_W-1:0] i_cfg_wdata = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [7:0]       i_value_byte = '0;
    logic             i_last_byte = 1'b0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [1:0]       o_outcome;
    logic [OUT_W-1:0] o_first_offset;
    logic [OUT_W-1:0] o_final_offset;

    // Header bytes waiting to be driven, and verdicts the parser still owes us.
    t_hdr_byte      pending_q[$];
    t_range_verdict verdict_q[$];
    logic [7:0]     hdr_q[$];

    // Shadow copy of the parser state and of the file size register.
    logic [OUT_W-1:0] size_cfg = '0;
    t_phase           phase_now = PH_PREFIX;
    t_early           early_now = EV_NONE;
    int               seen_count = 0;
    logic [63:0]      start_acc = '0;
    logic [63:0]      end_acc = '0;
    logic             end_seen = 1'b0;

    logic        in_accept = 1'b0;
    int unsigned cyc_count = 0;
    int unsigned fail_count = 0;
    int unsigned queued_bytes = 0;

    http_byte_range_parser i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_value_byte   (i_value_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_outcome      (o_outcome),
        .o_first_offset (o_first_offset),
        .o_final_offset (o_final_offset)
    );

    always #1 i_clk = ~i_clk;

    // Advances the shadow parser by one header byte. On the marked byte the verdict is
    // queued and the shadow state clears for the next header value.
    task automatic range_step(input logic [7:0] b, input logic lastb);
        t_range_verdict v;
        logic [63:0]    end_pick;
        logic           is_num;
        is_num = (b >= CH_ZERO) && (b <= CH_NINE);
        if (seen_count < 8) seen_count++;
        if (early_now == EV_NONE) begin
            case (phase_now)
                PH_PREFIX: begin
                    if (seen_count > 6) begin
                        early_now = EV_FULL;
                    end else if (b != UNIT_TEXT[8*(6-seen_count) +: 8]) begin
                        early_now = EV_FULL;
                    end else if (seen_count == 6) begin
                        phase_now = PH_LEAD;
                    end
                end
                PH_LEAD: begin
                    if (is_num) begin
                        start_acc = 64'(b - CH_ZERO);
                        phase_now = PH_START;
                    end else if (b != CH_SPACE) begin
                        early_now = EV_BAD;
                    end
                end
                PH_START: begin
                    if (is_num) begin
                        if (start_acc >= DEC_LIMIT) early_now = EV_BAD;
                        else start_acc = start_acc * 64'd10 + 64'(b - CH_ZERO);
                    end else if (b == CH_SPACE) begin
                        phase_now = PH_GAP;
                    end else if (b == CH_DASH) begin
                        phase_now = PH_ENDLEAD;
                    end else begin
                        early_now = EV_BAD;
                    end
                end
                PH_GAP: begin
                    if (b == CH_DASH) phase_now = PH_ENDLEAD;
                    else if (b != CH_SPACE) early_now = EV_BAD;
                end
                PH_ENDLEAD: begin
                    // A lone NUL as the final byte stands for an open end.
                    if (is_num) begin
                        end_acc = 64'(b - CH_ZERO);
                        end_seen = 1'b1;
                        phase_now = PH_ENDNUM;
                    end else if (b != CH_SPACE && !(b == CH_NUL && lastb)) begin
                        early_now = EV_FULL;
                    end
                end
                PH_ENDNUM: begin
                    if (is_num) begin
                        if (end_acc >= DEC_LIMIT) early_now = EV_BAD;
                        else end_acc = end_acc * 64'd10 + 64'(b - CH_ZERO);
                    end else if (b == CH_SPACE || b == CH_NUL) begin
                        phase_now = PH_TAIL;
                    end else begin
                        early_now = EV_FULL;
                    end
                end
                PH_TAIL: begin
                    if (b != CH_SPACE && b != CH_NUL) early_now = EV_FULL;
                end
                default: early_now = EV_FULL;
            endcase
        end
        if (lastb) begin
            v.outcome = OUTCOME_FULL;
            v.first_offset = '0;
            v.final_offset = '0;
            // An empty file or a short value wins over anything decided earlier.
            if (size_cfg == '0 || seen_count < 8) begin
                v.outcome = OUTCOME_FULL;
            end else if (early_now == EV_BAD) begin
                v.outcome = OUTCOME_BAD;
            end else if (early_now == EV_FULL) begin
                v.outcome = OUTCOME_FULL;
            end else if (phase_now == PH_START || phase_now == PH_GAP) begin
                v.outcome = OUTCOME_BAD;
            end else if (phase_now == PH_ENDLEAD || phase_now == PH_ENDNUM ||
                         phase_now == PH_TAIL) begin
                end_pick = end_seen ? end_acc : {1'b0, size_cfg} - 64'd1;
                if (end_pick >= {1'b0, size_cfg}) end_pick = {1'b0, size_cfg} - 64'd1;
                if (start_acc > end_pick) begin
                    v.outcome = OUTCOME_BAD;
                end else begin
                    v.outcome = OUTCOME_PARTIAL;
                    v.first_offset = start_acc[OUT_W-1:0];
                    v.final_offset = end_pick[OUT_W-1:0];
                end
            end
            verdict_q.push_back(v);
            phase_now = PH_PREFIX;
            early_now = EV_NONE;
            seen_count = 0;
            start_acc = '0;
            end_acc = '0;
            end_seen = 1'b0;
        end
    endtask

    // A long window with no idling on either side.
    function automatic logic take_break();
        return !(cyc_count >= 1200 && cyc_count < 2200) &&
               ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // Input side: a transfer at the rising edge runs the shadow parser on that byte.
    always @(posedge i_clk) begin
        cyc_count <= cyc_count + 1;
        in_accept <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) range_step(i_value_byte, i_last_byte);
    end

    // Driver: presents the next header byte at the falling edge once the previous one
    // has gone through, or leaves a gap now and then.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_accept)) begin
            if (pending_q.size() > 0 && !take_break()) begin
                i_in_valid <= 1'b1;
                i_value_byte <= pending_q[0].value;
                i_last_byte <= pending_q[0].last;
                pending_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= i_rst_n && !take_break();
    end

    // Monitor: every verdict transfer is held against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdict_q.size() == 0) begin
                $error("verdict with none expected: outcome %0d first %0d final %0d",
                       o_outcome, o_first_offset, o_final_offset);
                fail_count++;
            end else begin
                if (o_outcome !== verdict_q[0].outcome) begin
                    $error("outcome: expected %0d, got %0d", verdict_q[0].outcome, o_outcome);
                    fail_count++;
                end
                if (o_first_offset !== verdict_q[0].first_offset) begin
                    $error("first_offset: expected %0d, got %0d",
                           verdict_q[0].first_offset, o_first_offset);
                    fail_count++;
                end
                if (o_final_offset !== verdict_q[0].final_offset) begin
                    $error("final_offset: expected %0d, got %0d",
                           verdict_q[0].final_offset, o_final_offset);
                    fail_count++;
                end
                verdict_q.pop_front();
            end
        end
    end

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) hdr_q.push_back(s[i]);
    endtask

    task automatic add_spaces(input int n);
        repeat (n) hdr_q.push_back(CH_SPACE);
    endtask

    // Moves the assembled header into the driver queue, marking its final byte.
    task automatic queue_header();
        t_hdr_byte hb;
        for (int i = 0; i < hdr_q.size(); i++) begin
            hb.value = hdr_q[i];
            hb.last = (i == hdr_q.size() - 1);
            pending_q.push_back(hb);
        end
        queued_bytes += hdr_q.size();
        hdr_q.delete();
    endtask

    task automatic send_text(input string s);
        add_text(s);
        queue_header();
    endtask

    // Offsets are mostly around the file size, with some long digit runs and some that
    // sit right at the decimal overflow boundary.
    task automatic add_offset();
        logic [63:0] r;
        logic [63:0] bound;
        int          pick;
        pick = $urandom_range(0, 9);
        r = {$urandom, $urandom};
        bound = (size_cfg == '0) ? 64'd2000 :
                {1'b0, size_cfg} + ({1'b0, size_cfg} >> 2) + 64'd2;
        if (pick < 6) begin
            add_text($sformatf("%0d", r % bound));
        end else if (pick == 6) begin
            add_text($sformatf("%0d", $urandom_range(0, 20)));
        end else if (pick < 9) begin
            repeat ($urandom_range(1, 21)) hdr_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end else begin
            add_text($sformatf("%0d%0d", DEC_LIMIT - $urandom_range(0, 2), $urandom_range(0, 9)));
        end
    endtask

    // Mostly well-formed ranges with random content; the rest is noise or damaged.
    task automatic random_header();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 14)) hdr_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            add_text("bytes=");
            if ($urandom_range(0, 3) == 0) add_spaces($urandom_range(1, 3));
            add_offset();
            if ($urandom_range(0, 4) == 0) add_spaces($urandom_range(1, 2));
            if ($urandom_range(0, 19) != 0) hdr_q.push_back(CH_DASH);
            if ($urandom_range(0, 4) == 0) add_spaces($urandom_range(1, 2));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: add_offset();
                8: hdr_q.push_back(CH_NUL);
                9: add_text(",0-1");
                default: ;
            endcase
            case ($urandom_range(0, 9))
                6, 7: repeat ($urandom_range(1, 3))
                        hdr_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_NUL);
                8: hdr_q.push_back(CH_NUL);
                9: hdr_q.push_back(8'($urandom_range(0, 255)));
                default: ;
            endcase
            if (kind < 30) begin
                case ($urandom_range(0, 2))
                    0: hdr_q[$urandom_range(0, hdr_q.size() - 1)] = 8'($urandom_range(0, 255));
                    1: repeat ($urandom_range(1, hdr_q.size() - 1)) void'(hdr_q.pop_back());
                    default: hdr_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
        queue_header();
    endtask

    task automatic random_headers(input int unsigned budget);
        int unsigned goal;
        goal = queued_bytes + budget;
        while (queued_bytes < goal) random_header();
    endtask

    // The file size may only change with nothing in flight, including bytes of a header
    // whose verdict is still in the pipeline.
    task automatic write_size(input logic [OUT_W-1:0] value);
        while (pending_q.size() != 0 || i_in_valid || verdict_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        size_cfg = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The file size still holds its reset value of zero.
        send_text("bytes=0-499");
        send_text("bytes=5-");
        random_headers(150);

        write_size(63'd1000);
        send_text("bytes=0-499");
        send_text("bytes=500-");
        send_text("bytes=0-99999");
        send_text("bytes=900-100");
        send_text("bytes= 5 - 9 ");
        send_text("bytes=x-5");
        send_text("bytes=55");
        send_text("bytes=5 5-9");
        send_text("bytes=5x-9");
        send_text("bytes=-5");
        send_text("bytes=5-,6-7");
        send_text("bytes=5-9,1-2");
        send_text("bytes=5-9 x");
        add_text("bytes=5-");
        hdr_q.push_back(CH_NUL);
        queue_header();
        add_text("bytes=5-");
        hdr_q.push_back(CH_NUL);
        hdr_q.push_back(CH_SPACE);
        queue_header();
        add_text("bytes=5-9");
        hdr_q.push_back(CH_NUL);
        hdr_q.push_back(CH_SPACE);
        hdr_q.push_back(CH_NUL);
        queue_header();
        send_text("Bytes=0-1");
        send_text("bytes=0");
        send_text("bytes=      ");
        send_text("bytes=9223372036854775800-");
        send_text("bytes=0-9223372036854775801");
        send_text("bytes=9223372036854775799-");
        send_text("bytes=1000-");
        send_text("bytes=999-999");
        repeat (9) hdr_q.push_back(8'hFF);
        queue_header();
        hdr_q.push_back(CH_NUL);
        queue_header();
        random_headers(300);

        write_size(SIZE_MAX[OUT_W-1:0]);
        send_text("bytes=0-");
        send_text("bytes=9223372036854775799-9223372036854775807");
        random_headers(350);

        write_size(63'd1);
        send_text("bytes=0-0");
        send_text("bytes=1-");
        random_headers(250);

        write_size({31'd0, $urandom});
        random_headers(300);

        write_size(63'({$urandom, $urandom}));
        random_headers(300);

        write_size('0);
        random_headers(100);

        write_size(63'd37);
        random_headers(250);

        while (pending_q.size() != 0 || i_in_valid || verdict_q.size() != 0) @(negedge i_clk);
        // Let any verdict the parser should not produce have time to show up.
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("[http_byte_range_parser] OK");
        end else begin
            $display("[http_byte_range_parser] ERROR");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #400000;
        $display("[http_byte_range_parser] ERROR");
        $finish;
    end

endmodule
